FILE: hw/rtl/hfua_pkg.sv
`timescale 1ns / 1ps

package hfua_pkg;

    localparam int LEN_W = 21;

    // NAL unit types
    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'd23;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    localparam logic [7:0] SC_ZERO = 8'h00;
    localparam logic [7:0] SC_ONE  = 8'h01;

    // length after start code plus header byte
    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(5);

    // packet status codes
    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // phase of the header byte, the last beat of a start code burst
    localparam logic [2:0] HDR_LAST = 3'd4;
    localparam logic [2:0] SC_ONE_PHASE = 3'd3;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       packet_start;
        logic       packet_end;
        logic       rtp_marker;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        logic             run_last;
        logic [1:0]       packet_status;
        logic [LEN_W-1:0] nal_length;
    } out_item_t;

    typedef enum logic [1:0] {
        K_BYTE,   // one data byte
        K_HDR,    // start code then header byte
        K_STAT    // status only, no data
    } entry_kind_t;

    typedef struct packed {
        entry_kind_t      kind;
        logic [7:0]       data;
        logic [1:0]       status;
        logic [LEN_W-1:0] len;
    } entry_t;

endpackage

FILE: hw/rtl/hfua_front.sv
`timescale 1ns / 1ps

module hfua_front
    import hfua_pkg::*;
#(
    parameter int unsigned MAX_NAL_BYTES = 1048576
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output logic     q_push,
    output entry_t   q_entry
);

    localparam logic [LEN_W-1:0] LEN_CAP =
        (MAX_NAL_BYTES < ((2 ** LEN_W) - 1)) ? LEN_W'(MAX_NAL_BYTES) : '1;

    typedef enum logic [1:0] {
        M_IDLE,
        M_SINGLE,
        M_FU,
        M_DROP
    } mode_t;

    typedef enum logic [1:0] {
        P_HEADER,
        P_FU_HDR,
        P_PAYLOAD
    } pos_t;

    mode_t            mode_reg, mode_next;
    pos_t             pos_reg, pos_next;
    logic [2:0]       fnri_reg, fnri_next;
    logic [LEN_W-1:0] frag_len_reg, frag_len_next;
    logic [LEN_W-1:0] single_len_reg, single_len_next;
    logic             ovf_reg, ovf_next;
    logic             push_next;
    entry_t           entry_next;
    logic             has_entry;

    always_comb
    begin
        logic [4:0] nal_type;
        nal_type        = item.payload_byte[4:0];
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        fnri_next       = fnri_reg;
        frag_len_next   = frag_len_reg;
        single_len_next = single_len_reg;
        ovf_next        = ovf_reg;
        has_entry       = 1'b0;
        entry_next      = '{kind: K_BYTE, data: item.payload_byte, status: ST_PENDING,
                            len: '0};

        if (item.packet_start || mode_reg != M_IDLE)
        begin
            if (item.packet_start)
            begin
                if (nal_type >= NAL_SINGLE_MIN && nal_type <= NAL_SINGLE_MAX)
                begin
                    mode_next       = M_SINGLE;
                    ovf_next        = 1'b0;
                    single_len_next = HDR_LEN;
                    pos_next        = P_PAYLOAD;
                    has_entry       = 1'b1;
                    entry_next.kind = K_HDR;
                    entry_next.len  = HDR_LEN;
                end
                else if (nal_type == NAL_FU_A)
                begin
                    mode_next = M_FU;
                    fnri_next = item.payload_byte[7:5];
                    pos_next  = P_FU_HDR;
                end
                else
                begin
                    mode_next = M_DROP;
                    pos_next  = P_PAYLOAD;
                end
            end
            else if (mode_reg == M_SINGLE)
            begin
                has_entry = 1'b1;
                if (single_len_reg >= LEN_CAP)
                begin
                    ovf_next        = 1'b1;
                    single_len_next = LEN_CAP;
                end
                else
                begin
                    single_len_next = single_len_reg + LEN_W'(1);
                end
                entry_next.len = single_len_next;
            end
            else if (mode_reg == M_FU)
            begin
                if (pos_reg == P_FU_HDR)
                begin
                    pos_next = P_PAYLOAD;
                    // first fragment, not also the last: rebuilt NAL header
                    if (item.payload_byte[7] && !item.rtp_marker)
                    begin
                        frag_len_next   = HDR_LEN;
                        ovf_next        = 1'b0;
                        has_entry       = 1'b1;
                        entry_next.kind = K_HDR;
                        entry_next.data = {fnri_reg, nal_type};
                        entry_next.len  = HDR_LEN;
                    end
                end
                else
                begin
                    has_entry = 1'b1;
                    if (frag_len_reg >= LEN_CAP)
                    begin
                        ovf_next      = 1'b1;
                        frag_len_next = LEN_CAP;
                    end
                    else
                    begin
                        frag_len_next = frag_len_reg + LEN_W'(1);
                    end
                    entry_next.len = frag_len_next;
                end
            end

            if (item.packet_end)
            begin
                if (mode_next == M_SINGLE)
                begin
                    entry_next.status = ovf_next ? ST_OVERFLOW : ST_COMPLETE;
                    entry_next.len    = single_len_next;
                    ovf_next          = 1'b0;
                end
                else if (mode_next == M_FU)
                begin
                    entry_next.len = frag_len_next;
                    if (item.rtp_marker)
                    begin
                        entry_next.status = ovf_next ? ST_OVERFLOW : ST_COMPLETE;
                        frag_len_next     = '0;
                        ovf_next          = 1'b0;
                    end
                    else
                    begin
                        entry_next.status = ovf_next ? ST_OVERFLOW : ST_PENDING;
                    end
                end
                else
                begin
                    entry_next.status = ST_DROPPED;
                    entry_next.len    = '0;
                end
                if (!has_entry)
                begin
                    has_entry       = 1'b1;
                    entry_next.kind = K_STAT;
                    entry_next.data = SC_ZERO;
                end
                mode_next = M_IDLE;
                pos_next  = P_HEADER;
            end
        end
        push_next = take && has_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            pos_reg        <= P_HEADER;
            fnri_reg       <= '0;
            frag_len_reg   <= '0;
            single_len_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (take)
        begin
            mode_reg       <= mode_next;
            pos_reg        <= pos_next;
            fnri_reg       <= fnri_next;
            frag_len_reg   <= frag_len_next;
            single_len_reg <= single_len_next;
            ovf_reg        <= ovf_next;
        end
    end

    assign q_push  = push_next;
    assign q_entry = entry_next;

endmodule

FILE: hw/rtl/hfua_queue.sv
`timescale 1ns / 1ps

module hfua_queue
    import hfua_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr,
    input  entry_t wr_entry,
    output logic   full,
    input  logic   rd,
    output logic   avail,
    output entry_t head
);

    logic [1:0] count_reg, count_next;
    entry_t     slot0_reg, slot0_next;
    entry_t     slot1_reg, slot1_next;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (rd && count_reg != 2'd0)
        begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
        if (wr)
        begin
            if (count_next == 2'd0)
            begin
                slot0_next = wr_entry;
            end
            else
            begin
                slot1_next = wr_entry;
            end
            count_next = count_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign full  = (count_reg == 2'd2);
    assign avail = (count_reg != 2'd0);
    assign head  = slot0_reg;

endmodule

FILE: hw/rtl/hfua_back.sv
`timescale 1ns / 1ps

module hfua_back
    import hfua_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_avail,
    input  entry_t    q_head,
    output logic      q_rd,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic       cur_valid_reg;
    entry_t     cur_reg;
    logic [2:0] phase_reg;
    logic       last_beat;
    logic       done;
    logic       load;

    assign last_beat = (cur_reg.kind != K_HDR) || (phase_reg == HDR_LAST);
    assign done      = cur_valid_reg && pop && last_beat;
    assign load      = q_avail && (!cur_valid_reg || done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            phase_reg     <= '0;
        end
        else
        begin
            if (load)
            begin
                cur_valid_reg <= 1'b1;
                phase_reg     <= '0;
            end
            else if (done)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (cur_valid_reg && pop)
            begin
                phase_reg <= phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_reg <= q_head;
        end
    end

    always_comb
    begin
        result.out_byte      = cur_reg.data;
        result.byte_valid    = 1'b1;
        result.run_last      = 1'b1;
        result.packet_status = cur_reg.status;
        result.nal_length    = cur_reg.len;
        case (cur_reg.kind)
            K_HDR:
            begin
                if (phase_reg != HDR_LAST)
                begin
                    // start code beats: 00 00 00 01
                    result.out_byte      = (phase_reg == SC_ONE_PHASE) ? SC_ONE : SC_ZERO;
                    result.run_last      = 1'b0;
                    result.packet_status = ST_PENDING;
                    result.nal_length    = LEN_W'(phase_reg) + LEN_W'(1);
                end
            end
            K_STAT:
            begin
                result.out_byte   = SC_ZERO;
                result.byte_valid = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign q_rd  = load;
    assign empty = !cur_valid_reg;

endmodule

FILE: hw/rtl/h264_rtp_fua_depacketizer.sv
`timescale 1ns / 1ps
// channel   dir  handshake            payload
// item      in   push / full          in_item_t  (payload byte, start, end, marker)
// result    out  pop / empty          out_item_t (byte, valid, last, status, length)
//
// One input byte per cycle while full is low; each byte yields 0, 1 or 5 result beats.
// The back end expands a start code burst into its result beats, advancing on each pop.
// Front end classifies combinationally into a two-entry queue; full rises only
// when the queue holds two entries. Asynchronous active-low reset, no init pass.
// Either side may stall freely; the other keeps going until the queue fills/drains.

module h264_rtp_fua_depacketizer
    import hfua_pkg::*;
#(
    parameter int unsigned MAX_NAL_BYTES = 1048576
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result
);

    logic   take;
    logic   q_push;
    entry_t q_entry;
    logic   q_rd;
    logic   q_avail;
    entry_t q_head;

    assign take = push && !full;

    hfua_front #(
        .MAX_NAL_BYTES(MAX_NAL_BYTES)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .item    (item),
        .q_push  (q_push),
        .q_entry (q_entry)
    );

    hfua_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_push),
        .wr_entry (q_entry),
        .full     (full),
        .rd       (q_rd),
        .avail    (q_avail),
        .head     (q_head)
    );

    hfua_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_avail (q_avail),
        .q_head  (q_head),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule
